// File: sv/dem_contact_force_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Contact force engine assertion macros
// Clocked checks on clk, with or without the rst_n guard.
// ----------------------------------------------------------------------------
`ifndef DEM_CONTACT_FORCE_ENGINE_UNIT_ASSERT_SVH
`define DEM_CONTACT_FORCE_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DCFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DCFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DCFE_ASSERT(lbl, prop, msg)
`define DCFE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: sv/dcfe_pkg.sv
// ----------------------------------------------------------------------------
// Contact force engine package
// Shared types, codes and fixed point helpers.
// ----------------------------------------------------------------------------
package dcfe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int UNIT_BITS     = 30;
  localparam int CNT_W         = 24;
  localparam int ACC_W         = 48;
  localparam int NUM_CFG       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int Q_DEPTH       = 2;
  localparam int Q_AW          = 1;

  localparam logic [60:0]      MAG_CAP  = {1'b1, 60'd0};
  localparam logic [30:0]      UNIT_ONE = {1'b1, 30'd0};
  localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  // material select
  localparam logic OP_PAIR = 1'b0;
  localparam logic OP_WALL = 1'b1;

  // register slot within a material bank
  localparam logic [1:0] CF_STIFF = 2'd0;
  localparam logic [1:0] CF_NDAMP = 2'd1;
  localparam logic [1:0] CF_TDAMP = 2'd2;
  localparam logic [1:0] CF_FRIC  = 2'd3;

  // shared arithmetic unit operations
  localparam logic [1:0] AR_MUL  = 2'd0;
  localparam logic [1:0] AR_DIV  = 2'd1;
  localparam logic [1:0] AR_SQRT = 2'd2;

  typedef struct packed {
    logic             op;
    logic             start;
    logic             contact;
    logic [2:0][31:0] sep;
    logic [2:0][31:0] vel;
    logic [30:0]      pen;
    logic [CNT_W-1:0] pair_cnt;
    logic [CNT_W-1:0] wall_cnt;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  kind;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } arith_rsp_t;

  // product >> s, capped at 2^60
  function automatic logic [60:0] cap_shr(input logic [127:0] p, input int unsigned s);
    logic [127:0] t;
    t = p >> s;
    if ((|t[127:61]) || (t[60:0] > MAG_CAP)) cap_shr = MAG_CAP;
    else cap_shr = t[60:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [62:0] v);
    if (v > 63'sd2147483647) sat32 = 32'h7FFF_FFFF;
    else if (v < -63'sd2147483648) sat32 = 32'h8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

// File: sv/dem_contact_force_engine_unit.sv
// ----------------------------------------------------------------------------
// DEM contact force engine
// Hertz-Mindlin normal force with viscous damping and Coulomb-capped tangential
// damping for one particle-particle or particle-wall contact per request. The
// front end takes a request every cycle while its two-entry queue has room,
// updates the pair and wall contact counters, and flags requests with no force
// (overlap at most zero, or zero separation). Those skip the arithmetic unit.
// A contact request runs through one shared arithmetic unit: 25 multiplies
// (four 32x32 partial products each), up to six 64-step divisions and three
// 32-step integer roots; fewer when the tangential speed rounds to zero.
// Results sit in an output register, so the front keeps accepting while a
// result waits. The eight coefficient registers (pair bank 0-3, wall bank 4-7)
// are written through the cfg port and must only change while the
// block is idle.
// Statistics (dissipated power, contact counts) clear on a step_start request.
// ----------------------------------------------------------------------------
module dem_contact_force_engine_unit #(
  parameter int FRAC_BITS = dcfe_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dcfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic                              in_step_start,
  input  logic signed [31:0]                in_sep_x,
  input  logic signed [31:0]                in_sep_y,
  input  logic signed [31:0]                in_sep_z,
  input  logic signed [31:0]                in_rel_vel_x,
  input  logic signed [31:0]                in_rel_vel_y,
  input  logic signed [31:0]                in_rel_vel_z,
  input  logic signed [31:0]                in_penetration,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_force_x,
  output logic signed [31:0]                out_force_y,
  output logic signed [31:0]                out_force_z,
  output logic                              out_in_contact,
  output logic [dcfe_pkg::ACC_W-1:0]        out_dissipation_total,
  output logic [dcfe_pkg::CNT_W-1:0]        out_pair_contact_count,
  output logic [dcfe_pkg::CNT_W-1:0]        out_wall_contact_count
);
  import dcfe_pkg::*;

  // coefficient bank; always ready
  logic [NUM_CFG-1:0][31:0] cfg_r;

  logic        q_valid, q_pop;
  item_t       q_item;
  logic [31:0] fx, fy, fz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // front: accept, count, classify, queue
  dcfe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_step_start (in_step_start),
    .in_sep_x      (in_sep_x),
    .in_sep_y      (in_sep_y),
    .in_sep_z      (in_sep_z),
    .in_vel_x      (in_rel_vel_x),
    .in_vel_y      (in_rel_vel_y),
    .in_vel_z      (in_rel_vel_z),
    .in_pen        (in_penetration),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back: force sequencer and dissipation accumulator
  dcfe_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .cfg             (cfg_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_force_x     (fx),
    .out_force_y     (fy),
    .out_force_z     (fz),
    .out_in_contact  (out_in_contact),
    .out_dissipation (out_dissipation_total),
    .out_pair_cnt    (out_pair_contact_count),
    .out_wall_cnt    (out_wall_contact_count)
  );

  assign out_force_x = $signed(fx);
  assign out_force_y = $signed(fy);
  assign out_force_z = $signed(fz);
endmodule

// File: sv/dcfe_front.sv
// ----------------------------------------------------------------------------
// Contact force engine front end
// Accepts contacts, updates counters, classifies, and queues for the back end.
// ----------------------------------------------------------------------------
`include "dem_contact_force_engine_unit_assert.svh"
module dcfe_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic                  in_step_start,
  input  logic [31:0]           in_sep_x,
  input  logic [31:0]           in_sep_y,
  input  logic [31:0]           in_sep_z,
  input  logic [31:0]           in_vel_x,
  input  logic [31:0]           in_vel_y,
  input  logic [31:0]           in_vel_z,
  input  logic [31:0]           in_pen,
  output logic                  q_valid,
  output dcfe_pkg::item_t       q_item,
  input  logic                  q_pop
);
  import dcfe_pkg::*;

  item_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, rp_r;
  logic [Q_AW:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt, wc_r, wc_nxt;
  logic             push, pop, pen_pos;
  item_t            item;

  assign in_ready = (cnt_r != Q_AW'(0) + (Q_AW+1)'(Q_DEPTH)) ? 1'b1 : 1'b0;
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (cnt_r != '0);
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];
  assign pen_pos  = !in_pen[31] && (in_pen[30:0] != '0);

  always_comb begin
    pc_nxt = in_step_start ? '0 : pc_r;
    wc_nxt = in_step_start ? '0 : wc_r;
    if (pen_pos) begin
      if (in_op == OP_WALL) begin
        if (wc_nxt != CNT_MAX) wc_nxt = wc_nxt + 1'b1;
      end else begin
        if (pc_nxt != CNT_MAX) pc_nxt = pc_nxt + 1'b1;
      end
    end
    item.op       = in_op;
    item.start    = in_step_start;
    item.contact  = pen_pos && ((in_sep_x | in_sep_y | in_sep_z) != '0);
    item.sep      = {in_sep_z, in_sep_y, in_sep_x};
    item.vel      = {in_vel_z, in_vel_y, in_vel_x};
    item.pen      = in_pen[30:0];
    item.pair_cnt = pc_nxt;
    item.wall_cnt = wc_nxt;
    cnt_nxt = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      pc_r  <= '0;
      wc_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
        pc_r <= pc_nxt;
        wc_r <= wc_nxt;
      end
      if (pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= item;
  end

  `DCFE_ASSERT(a_q_bound, cnt_r <= (Q_AW+1)'(Q_DEPTH), "queue count over depth")
  `DCFE_ASSERT(a_q_ready, (cnt_r == (Q_AW+1)'(Q_DEPTH)) |-> !in_ready, "ready while full")
endmodule

// File: sv/dcfe_arith.sv
// ----------------------------------------------------------------------------
// Contact force engine arithmetic unit
// Shared multi-cycle multiply (32x32 partials), restoring divide, integer root.
// ----------------------------------------------------------------------------
`include "dem_contact_force_engine_unit_assert.svh"
module dcfe_arith (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dcfe_pkg::arith_req_t   req,
  output dcfe_pkg::arith_rsp_t   rsp
);
  import dcfe_pkg::*;

  logic         busy_r, busy_nxt, done_r, done_nxt, ppv_r, ppv_nxt;
  logic [1:0]   kind_r, kind_nxt, ppsh_r, ppsh_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt, pp_r, pp_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [31:0]  rem_r, rem_nxt;
  logic [63:0]  quo_r, quo_nxt, x_r, x_nxt, r_r, r_nxt, bit_r, bit_nxt;
  logic [32:0]  dtmp;
  logic [31:0]  al, bl;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    kind_nxt = kind_r;
    cnt_nxt  = cnt_r;
    a_nxt = a_r; b_nxt = b_r; pp_nxt = pp_r; ppv_nxt = ppv_r; ppsh_nxt = ppsh_r;
    acc_nxt = acc_r; rem_nxt = rem_r; quo_nxt = quo_r;
    x_nxt = x_r; r_nxt = r_r; bit_nxt = bit_r;
    al = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    bl = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    dtmp = {rem_r, quo_r[63]};
    if (req.start) begin
      busy_nxt = 1'b1;
      kind_nxt = req.kind;
      cnt_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      ppv_nxt  = 1'b0;
      acc_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.a;
      x_nxt    = req.a;
      r_nxt    = '0;
      bit_nxt  = {2'b01, 62'd0};
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      case (kind_r)
        AR_MUL: begin
          if (ppv_r) acc_nxt = acc_r + (128'(pp_r) << {ppsh_r, 5'd0});
          if (cnt_r < 7'd4) begin
            pp_nxt   = 64'(al) * 64'(bl);
            ppsh_nxt = 2'(cnt_r[1]) + 2'(cnt_r[0]);
            ppv_nxt  = 1'b1;
          end else begin
            ppv_nxt  = 1'b0;
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        AR_DIV: begin
          if (dtmp >= {1'b0, b_r[31:0]}) begin
            rem_nxt = 32'(dtmp - {1'b0, b_r[31:0]});
            quo_nxt = {quo_r[62:0], 1'b1};
          end else begin
            rem_nxt = dtmp[31:0];
            quo_nxt = {quo_r[62:0], 1'b0};
          end
          if (cnt_r == 7'd63) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: begin
          if (x_r >= r_r + bit_r) begin
            x_nxt = x_r - (r_r + bit_r);
            r_nxt = (r_r >> 1) + bit_r;
          end else begin
            r_nxt = r_r >> 1;
          end
          bit_nxt = bit_r >> 2;
          if (cnt_r == 7'd31) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ppv_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ppv_r  <= ppv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; cnt_r <= cnt_nxt; a_r <= a_nxt; b_r <= b_nxt;
    pp_r <= pp_nxt; ppsh_r <= ppsh_nxt; acc_r <= acc_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; x_r <= x_nxt; r_r <= r_nxt; bit_r <= bit_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    case (kind_r)
      AR_MUL:  rsp.res = acc_r;
      AR_DIV:  rsp.res = 128'(quo_r);
      default: rsp.res = 128'(r_r);
    endcase
  end

  `DCFE_ASSERT(a_ar_start_idle, req.start |-> !busy_r, "arith start while busy")
endmodule

// File: sv/dcfe_back.sv
// ----------------------------------------------------------------------------
// Contact force engine back end
// Sequencer that runs one contact through the shared arithmetic unit.
// ----------------------------------------------------------------------------
`include "dem_contact_force_engine_unit_assert.svh"
module dcfe_back #(
  parameter int FRAC_BITS = dcfe_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  dcfe_pkg::item_t               q_item,
  output logic                          q_pop,
  input  logic [dcfe_pkg::NUM_CFG-1:0][31:0] cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_force_x,
  output logic [31:0]                   out_force_y,
  output logic [31:0]                   out_force_z,
  output logic                          out_in_contact,
  output logic [dcfe_pkg::ACC_W-1:0]    out_dissipation,
  output logic [dcfe_pkg::CNT_W-1:0]    out_pair_cnt,
  output logic [dcfe_pkg::CNT_W-1:0]    out_wall_cnt
);
  import dcfe_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_DSQ = 5'd1,  ST_DIST = 5'd2,  ST_NDIV = 5'd3,
                         ST_DOT  = 5'd4,  ST_SQ  = 5'd5,  ST_O15  = 5'd6,  ST_ELA  = 5'd7,
                         ST_DMP  = 5'd8,  ST_VT  = 5'd9,  ST_VSQ  = 5'd10, ST_FN   = 5'd11,
                         ST_TS   = 5'd12, ST_REQ = 5'd13, ST_LIM  = 5'd14, ST_UDIV = 5'd15,
                         ST_UMUL = 5'd16, ST_PW1 = 5'd17, ST_PW2  = 5'd18, ST_FIN  = 5'd19;

  arith_req_t req;
  arith_rsp_t rsp;

  logic [4:0]        state_r, state_nxt;
  logic              wait_r, wait_nxt;
  logic [1:0]        idx_r, idx_nxt;
  item_t             it_r, it_nxt;
  logic [63:0]       dsq_r, dsq_nxt, tsq_r, tsq_nxt;
  logic [31:0]       dist_r, dist_nxt, sq_r, sq_nxt, ts_r, ts_nxt;
  logic [2:0][30:0]  nmag_r, nmag_nxt;
  logic signed [63:0] dotp_r, dotp_nxt;
  logic [32:0]       vnmag_r, vnmag_nxt;
  logic              vnneg_r, vnneg_nxt;
  logic [60:0]       o15_r, o15_nxt, ela_r, ela_nxt, dmp_r, dmp_nxt, fn_r, fn_nxt;
  logic [60:0]       rq_r, rq_nxt, mag_r, mag_nxt, pw_r, pw_nxt;
  logic [2:0][34:0]  vt_r, vt_nxt;
  logic [30:0]       umag_r, umag_nxt;
  logic [2:0][62:0]  f_r, f_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              ov_r, ov_nxt, load;

  logic [31:0]        di, vi, d_abs, v_abs;
  logic               dneg, vneg;
  logic [34:0]        vti, vt_abs;
  logic [60:0]        pf, pu;
  logic signed [63:0] term, dot_new;
  logic [63:0]        dot_abs;
  logic signed [62:0] fsum, p63;
  logic [64:0]        tsum;
  logic [61:0]        power;
  logic [62:0]        asum;
  logic [34:0]        vsx;

  dcfe_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    di     = it_r.sep[idx_r];
    vi     = it_r.vel[idx_r];
    dneg   = di[31];
    vneg   = vi[31];
    d_abs  = dneg ? (~di + 32'd1) : di;
    v_abs  = vneg ? (~vi + 32'd1) : vi;
    vti    = vt_r[idx_r];
    vt_abs = vti[34] ? (~vti + 35'd1) : vti;
    vsx    = {{3{vi[31]}}, vi};
    pf     = cap_shr(rsp.res, FRAC_BITS);
    pu     = cap_shr(rsp.res, UNIT_BITS);
    p63    = $signed({2'b00, pu});
    term   = $signed({2'b00, rsp.res[61:0]});
    dot_new = (vneg ^ dneg) ? dotp_r - term : dotp_r + term;
    dot_abs = dot_new[63] ? 64'(-dot_new) : 64'(dot_new);
    fsum   = $signed({2'b00, ela_r}) +
             (vnneg_r ? $signed({2'b00, pf}) : -$signed({2'b00, pf}));
    tsum   = {1'b0, tsq_r} + {1'b0, rsp.res[63:0]};
    power  = {1'b0, pw_r} + {1'b0, pf};
    asum   = 63'(acc_r) + 63'(power);

    req.start = 1'b0;
    req.kind  = AR_MUL;
    req.a     = '0;
    req.b     = '0;
    case (state_r)
      ST_DSQ:  begin req.a = 64'(d_abs); req.b = 64'(d_abs); end
      ST_DIST: begin req.kind = AR_SQRT; req.a = dsq_r; end
      ST_NDIV: begin req.kind = AR_DIV; req.a = {2'b00, d_abs, 30'd0}; req.b = 64'(dist_r); end
      ST_DOT:  begin req.a = 64'(v_abs); req.b = 64'(nmag_r[idx_r]); end
      ST_SQ:   begin req.kind = AR_SQRT; req.a = 64'(it_r.pen) << FRAC_BITS; end
      ST_O15:  begin req.a = 64'(it_r.pen); req.b = 64'(sq_r); end
      ST_ELA:  begin req.a = 64'(cfg[{it_r.op, CF_STIFF}]); req.b = 64'(o15_r); end
      ST_DMP:  begin req.a = 64'(vnmag_r); req.b = 64'(cfg[{it_r.op, CF_NDAMP}]); end
      ST_VT:   begin req.a = 64'(nmag_r[idx_r]); req.b = 64'(vnmag_r); end
      ST_VSQ:  begin req.a = 64'(vt_abs); req.b = 64'(vt_abs); end
      ST_FN:   begin req.a = 64'(nmag_r[idx_r]); req.b = 64'(fn_r); end
      ST_TS:   begin req.kind = AR_SQRT; req.a = tsq_r; end
      ST_REQ:  begin req.a = 64'(cfg[{it_r.op, CF_TDAMP}]); req.b = 64'(ts_r); end
      ST_LIM:  begin req.a = 64'(cfg[{it_r.op, CF_FRIC}]); req.b = 64'(fn_r); end
      ST_UDIV: begin req.kind = AR_DIV; req.a = {vt_abs[33:0], 30'd0}; req.b = 64'(ts_r); end
      ST_UMUL: begin req.a = 64'(umag_r); req.b = 64'(mag_r); end
      ST_PW1:  begin req.a = 64'(mag_r); req.b = 64'(ts_r); end
      ST_PW2:  begin req.a = 64'(dmp_r); req.b = 64'(vnmag_r); end
      default: ;
    endcase

    state_nxt = state_r; wait_nxt = wait_r; idx_nxt = idx_r; it_nxt = it_r;
    dsq_nxt = dsq_r; tsq_nxt = tsq_r; dist_nxt = dist_r; sq_nxt = sq_r; ts_nxt = ts_r;
    nmag_nxt = nmag_r; dotp_nxt = dotp_r; vnmag_nxt = vnmag_r; vnneg_nxt = vnneg_r;
    o15_nxt = o15_r; ela_nxt = ela_r; dmp_nxt = dmp_r; fn_nxt = fn_r; rq_nxt = rq_r;
    mag_nxt = mag_r; pw_nxt = pw_r; vt_nxt = vt_r; umag_nxt = umag_r; f_nxt = f_r;
    acc_nxt = acc_r; q_pop = 1'b0; load = 1'b0;

    if (state_r == ST_IDLE) begin
      if (q_valid) begin
        q_pop    = 1'b1;
        it_nxt   = q_item;
        idx_nxt  = '0;
        dsq_nxt  = '0;
        tsq_nxt  = '0;
        dotp_nxt = '0;
        f_nxt    = '0;
        if (q_item.start) acc_nxt = '0;
        state_nxt = q_item.contact ? ST_DSQ : ST_FIN;
      end
    end else if (state_r == ST_FIN) begin
      if (!ov_r || out_ready) begin
        load      = 1'b1;
        state_nxt = ST_IDLE;
      end
    end else if (!wait_r) begin
      req.start = 1'b1;
      wait_nxt  = 1'b1;
    end else if (rsp.done) begin
      wait_nxt = 1'b0;
      case (state_r)
        ST_DSQ: begin
          dsq_nxt = dsq_r + rsp.res[63:0];
          if (idx_r == 2'd2) begin idx_nxt = '0; state_nxt = ST_DIST; end
          else idx_nxt = idx_r + 2'd1;
        end
        ST_DIST: begin dist_nxt = rsp.res[31:0]; state_nxt = ST_NDIV; end
        ST_NDIV: begin
          nmag_nxt[idx_r] = rsp.res[30:0];
          if (idx_r == 2'd2) begin idx_nxt = '0; state_nxt = ST_DOT; end
          else idx_nxt = idx_r + 2'd1;
        end
        ST_DOT: begin
          dotp_nxt = dot_new;
          if (idx_r == 2'd2) begin
            idx_nxt   = '0;
            vnmag_nxt = dot_abs[62:30];
            vnneg_nxt = dot_new[63] && (dot_abs[62:30] != '0);
            state_nxt = ST_SQ;
          end else idx_nxt = idx_r + 2'd1;
        end
        ST_SQ:  begin sq_nxt = rsp.res[31:0]; state_nxt = ST_O15; end
        ST_O15: begin o15_nxt = pf; state_nxt = ST_ELA; end
        ST_ELA: begin ela_nxt = pf; state_nxt = ST_DMP; end
        ST_DMP: begin
          dmp_nxt = pf;
          if (fsum[62] || (fsum == '0)) fn_nxt = '0;
          else if (fsum[61:0] > 62'(MAG_CAP)) fn_nxt = MAG_CAP;
          else fn_nxt = fsum[60:0];
          state_nxt = ST_VT;
        end
        ST_VT: begin
          // subtract the normal part, signed by n and by vn
          vt_nxt[idx_r] = (dneg ^ vnneg_r) ? vsx + {1'b0, pu[33:0]} : vsx - {1'b0, pu[33:0]};
          state_nxt = ST_VSQ;
        end
        ST_VSQ: begin
          tsq_nxt   = tsum[64] ? '1 : tsum[63:0];
          state_nxt = ST_FN;
        end
        ST_FN: begin
          f_nxt[idx_r] = dneg ? -p63 : p63;
          if (idx_r == 2'd2) begin idx_nxt = '0; state_nxt = ST_TS; end
          else begin idx_nxt = idx_r + 2'd1; state_nxt = ST_VT; end
        end
        ST_TS: begin
          ts_nxt    = rsp.res[31:0];
          state_nxt = (rsp.res[31:0] == '0) ? ST_FIN : ST_REQ;
        end
        ST_REQ: begin rq_nxt = pf; state_nxt = ST_LIM; end
        ST_LIM: begin mag_nxt = (pf < rq_r) ? pf : rq_r; state_nxt = ST_UDIV; end
        ST_UDIV: begin
          umag_nxt  = (rsp.res[63:0] > 64'(UNIT_ONE)) ? UNIT_ONE : rsp.res[30:0];
          state_nxt = ST_UMUL;
        end
        ST_UMUL: begin
          f_nxt[idx_r] = vti[34] ? $signed(f_r[idx_r]) + p63 : $signed(f_r[idx_r]) - p63;
          if (idx_r == 2'd2) begin idx_nxt = '0; state_nxt = ST_PW1; end
          else begin idx_nxt = idx_r + 2'd1; state_nxt = ST_UDIV; end
        end
        ST_PW1: begin pw_nxt = pf; state_nxt = ST_PW2; end
        ST_PW2: begin
          acc_nxt   = (asum > 63'(ACC_MAX)) ? ACC_MAX : asum[ACC_W-1:0];
          state_nxt = ST_FIN;
        end
        default: state_nxt = ST_IDLE;
      endcase
    end

    ov_nxt = load ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
      idx_r   <= '0;
      acc_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r <= it_nxt; dsq_r <= dsq_nxt; tsq_r <= tsq_nxt; dist_r <= dist_nxt;
    sq_r <= sq_nxt; ts_r <= ts_nxt; nmag_r <= nmag_nxt; dotp_r <= dotp_nxt;
    vnmag_r <= vnmag_nxt; vnneg_r <= vnneg_nxt; o15_r <= o15_nxt; ela_r <= ela_nxt;
    dmp_r <= dmp_nxt; fn_r <= fn_nxt; rq_r <= rq_nxt; mag_r <= mag_nxt; pw_r <= pw_nxt;
    vt_r <= vt_nxt; umag_r <= umag_nxt; f_r <= f_nxt;
    if (load) begin
      out_force_x     <= sat32(f_r[0]);
      out_force_y     <= sat32(f_r[1]);
      out_force_z     <= sat32(f_r[2]);
      out_in_contact  <= (f_r[0] != '0) || (f_r[1] != '0) || (f_r[2] != '0);
      out_dissipation <= acc_r;
      out_pair_cnt    <= it_r.pair_cnt;
      out_wall_cnt    <= it_r.wall_cnt;
    end
  end

  assign out_valid = ov_r;

  `DCFE_ASSERT(a_idle_no_wait, (state_r == ST_IDLE) |-> !wait_r, "waiting while idle")
  `DCFE_ASSERT(a_done_waited, rsp.done |-> wait_r, "arith result not requested")
  `DCFE_ASSERT(a_contact_flag, ov_r |-> (out_in_contact == ((out_force_x != '0) || (out_force_y != '0) || (out_force_z != '0))), "contact flag disagrees with force")
endmodule
